// ===== hw/rtl/scfp_pkg.sv =====
`default_nettype none

package scfp_pkg;

   // Default size of the frame buffer in bytes.
   localparam int MAX_FRAME_BYTES_DEF = 16;

   // Command codes carried in byte 1 of a frame.
   localparam logic [7:0] CMD_INSTRUCTION = 8'h11;
   localparam logic [7:0] CMD_SPEED       = 8'h22;
   localparam logic [7:0] CMD_BUS         = 8'h88;

   // Configuration register indexes.
   localparam logic [0:0] CSR_HEADER = 1'b0;
   localparam logic [0:0] CSR_TAIL   = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [7:0] HEADER_RESET = 8'd123;
   localparam logic [7:0] TAIL_RESET   = 8'd125;

   // Number of payload bytes a bus frame can carry.
   localparam int BUS_BYTES = 8;

   typedef enum logic [2:0] {
      KIND_UNKNOWN     = 3'd0,
      KIND_INSTRUCTION = 3'd1,
      KIND_SPEED       = 3'd2,
      KIND_BUS         = 3'd3,
      KIND_OVERRUN     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [3:0]  payload_length;
      logic [63:0] bus_payload;
      logic [7:0]  speed_b;
      logic [7:0]  speed_a;
      logic [7:0]  instruction_value;
      logic [7:0]  command_byte;
      kind_type    frame_kind;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/scfp_parser.sv =====
`default_nettype none

module scfp_parser #(
   parameter int MAX_FRAME_BYTES = scfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   input  wire logic [7:0]           header_byte,
   input  wire logic [7:0]           tail_byte,
   output logic                      has_result,
   output scfp_pkg::result_type      result
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
   // Only entries 1 through 9 are ever read back.
   localparam int KEEP = (MAX_FRAME_BYTES < 10) ? MAX_FRAME_BYTES : 10;
   // A small buffer never reaches a full bus payload, so the limit is then the depth.
   localparam int FULL_INT = (MAX_FRAME_BYTES < scfp_pkg::BUS_BYTES + 2) ?
                             MAX_FRAME_BYTES : scfp_pkg::BUS_BYTES + 2;
   localparam logic [CNT_W:0] MAX_POS = (CNT_W + 1)'(MAX_FRAME_BYTES);
   localparam logic [CNT_W:0] FULL_POS = (CNT_W + 1)'(FULL_INT);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [7:0]       store_ff [1:KEEP-1];
   logic [7:0]       instr_ff;
   logic [7:0]       instr_in;
   logic [7:0]       speed_a_ff;
   logic [7:0]       speed_a_in;
   logic [7:0]       speed_b_ff;
   logic [7:0]       speed_b_in;

   logic [7:0]       view [1:3];
   logic [7:0]       lane [0:scfp_pkg::BUS_BYTES-1];
   logic [CNT_W:0]   next_idx;
   logic [CNT_W:0]   len_wide;
   logic             hunting;
   logic             drop;
   logic             done;
   logic             overrun;
   logic [63:0]      payload;

   // Entries as seen after the current byte is written.
   for (genvar k = 1; k <= 3; k++) begin : g_view
      assign view[k] = (count_ff == CNT_W'(k)) ? rx_byte : store_ff[k];
   end

   for (genvar j = 0; j < scfp_pkg::BUS_BYTES; j++) begin : g_lane
      if (j + 2 < KEEP) begin : g_real
         assign lane[j] = ((CNT_W + 1)'(j + 2) < {1'b0, count_ff}) ? store_ff[j + 2] : 8'd0;
      end else begin : g_none
         assign lane[j] = 8'd0;
      end
   end

   always_comb begin
      hunting  = (count_ff == '0);
      drop     = hunting && (rx_byte != header_byte);
      done     = !drop && (rx_byte == tail_byte);
      next_idx = {1'b0, count_ff} + (CNT_W + 1)'(1);
      overrun  = !drop && !done && (next_idx == MAX_POS);
      has_result = done || overrun;

      payload = '0;
      for (int j = 0; j < scfp_pkg::BUS_BYTES; j++) begin
         payload[8*j +: 8] = lane[j];
      end

      if ({1'b0, count_ff} >= FULL_POS) begin
         len_wide = (CNT_W + 1)'(scfp_pkg::BUS_BYTES);
      end else if ({1'b0, count_ff} > (CNT_W + 1)'(2)) begin
         len_wide = {1'b0, count_ff} - (CNT_W + 1)'(2);
      end else begin
         len_wide = '0;
      end

      instr_in   = instr_ff;
      speed_a_in = speed_a_ff;
      speed_b_in = speed_b_ff;
      result     = '0;
      result.command_byte = view[1];

      if (overrun) begin
         result.frame_kind = scfp_pkg::KIND_OVERRUN;
      end else begin
         case (view[1])
            scfp_pkg::CMD_INSTRUCTION: begin
               instr_in = view[1];
               result.frame_kind = scfp_pkg::KIND_INSTRUCTION;
            end
            scfp_pkg::CMD_SPEED: begin
               speed_a_in = view[2];
               speed_b_in = view[3];
               result.frame_kind = scfp_pkg::KIND_SPEED;
            end
            scfp_pkg::CMD_BUS: begin
               result.frame_kind     = scfp_pkg::KIND_BUS;
               result.bus_payload    = payload;
               result.payload_length = 4'(len_wide);
            end
            default: begin
               result.frame_kind = scfp_pkg::KIND_UNKNOWN;
            end
         endcase
      end

      if (!done) begin
         instr_in   = instr_ff;
         speed_a_in = speed_a_ff;
         speed_b_in = speed_b_ff;
      end

      result.instruction_value = instr_in;
      result.speed_a           = speed_a_in;
      result.speed_b           = speed_b_in;

      if (drop || done || overrun) begin
         count_in = '0;
      end else begin
         count_in = next_idx[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         instr_ff   <= 8'd0;
         speed_a_ff <= 8'd0;
         speed_b_ff <= 8'd0;
      end else if (step) begin
         count_ff   <= count_in;
         instr_ff   <= instr_in;
         speed_a_ff <= speed_a_in;
         speed_b_ff <= speed_b_in;
      end
   end

   for (genvar k = 1; k < KEEP; k++) begin : g_store
      always_ff @(posedge clock) begin
         if (step && (count_ff == CNT_W'(k))) begin
            store_ff[k] <= rx_byte;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/scfp_out_reg.sv =====
`default_nettype none

module scfp_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire scfp_pkg::result_type data_in,
   input  wire logic                 ready,
   output logic                      valid,
   output scfp_pkg::result_type      data_out
);

   logic                 valid_ff;
   logic                 valid_in;
   scfp_pkg::result_type data_ff;

   // A held result stays until taken; a new one may replace it in the same cycle.
   assign valid_in = load || (valid_ff && !ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid    = valid_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_command_frame_parser_core.sv =====
// A taken byte waits in the input register and is parsed as it moves on into the parser;
// a result it causes is registered in the output register and offered on rsp_ from there.
// Throughput: one byte per cycle, sustained, whenever the result side is not stalled.
// Reset (synchronous, active high) returns to hunting, clears the held values and the
// output register, and loads header 123 and tail 125. The frame buffer is not cleared.
`default_nettype none

module serial_command_frame_parser_core #(
   parameter int MAX_FRAME_BYTES = scfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [2:0] frame_kind, [10:3] command_byte, [18:11] instruction_value,
   // [26:19] speed_a, [34:27] speed_b, [98:35] bus_payload,
   // [102:99] payload_length, [103] zero
   output logic [103:0]      rsp_tdata,

   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_addr,
   input  wire logic [7:0]   csr_wdata
);

   // Configuration registers. A write takes effect at once, so it is meant to
   // come while no byte waits in the input register.
   logic [7:0] header_ff;
   logic [7:0] tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= scfp_pkg::HEADER_RESET;
         tail_ff   <= scfp_pkg::TAIL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            scfp_pkg::CSR_HEADER: header_ff <= csr_wdata;
            scfp_pkg::CSR_TAIL:   tail_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register. It holds one byte; the byte moves on into the parser
   // whenever the output register can take whatever result it may produce.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       out_valid;

   assign advance     = in_valid_ff && (!out_valid || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Parser: frame state, buffer, held values, and the result decode.
   logic                 has_result;
   scfp_pkg::result_type result;

   scfp_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .header_byte (header_ff),
      .tail_byte   (tail_ff),
      .has_result  (has_result),
      .result      (result)
   );

   // Output register. A completed or dropped frame gives exactly one transfer.
   scfp_pkg::result_type out_data;

   scfp_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && has_result),
      .data_in  (result),
      .ready    (rsp_tready),
      .valid    (out_valid),
      .data_out (out_data)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {1'b0,
                        out_data.payload_length,
                        out_data.bus_payload,
                        out_data.speed_b,
                        out_data.speed_a,
                        out_data.instruction_value,
                        out_data.command_byte,
                        out_data.frame_kind};

endmodule

`default_nettype wire

// ===== test/serial_command_frame_parser_core_tb.sv =====
module serial_command_frame_parser_core_tb;

   // The buffer depth of the block under test; it uses its default parameter.
   localparam int FRAME_DEPTH = scfp_pkg::MAX_FRAME_BYTES_DEF;
   // Cycles added to the result side's random stall for the one long back-pressure stretch.
   localparam int HOLD_CYCLES = 300;
   // Consecutive cycles without any transfer after which the run is declared hung.
   // The longest legal quiet stretch is the hold above plus one sender gap and one
   // receiver stall, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_addr = scfp_pkg::CSR_HEADER;
   logic [7:0]   csr_wdata = '0;

   // When set, both the sender and the receiver skip their random idle cycles for
   // the current frame, so that back-to-back transfers also get exercised.
   bit          calm = 1'b0;
   // Raised once by the stimulus; the receiver then adds HOLD_CYCLES to its next stall.
   bit          squeeze_now = 1'b0;
   int unsigned bytes_sent = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles = 0;

   serial_command_frame_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Frame result board: it mirrors the parser state (frame buffer, fill index, held
   // instruction and speeds, header and tail values), works out the result that each
   // accepted byte causes, and compares arriving results against them in order.
   class frame_result_board;
      logic [7:0]  header_value;
      logic [7:0]  tail_value;
      logic [7:0]  store [FRAME_DEPTH];
      int unsigned next_index;
      logic [7:0]  instr_hold;
      logic [7:0]  speed_a_hold;
      logic [7:0]  speed_b_hold;
      scfp_pkg::result_type awaited_results [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned kind_seen [5];

      function new();
         header_value = scfp_pkg::HEADER_RESET;
         tail_value   = scfp_pkg::TAIL_RESET;
         next_index   = 0;
         instr_hold   = '0;
         speed_a_hold = '0;
         speed_b_hold = '0;
         mismatches   = 0;
         checked      = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function void set_register(logic [0:0] index, logic [7:0] value);
         case (index)
            scfp_pkg::CSR_HEADER: header_value = value;
            scfp_pkg::CSR_TAIL:   tail_value = value;
            default:    ;
         endcase
      endfunction

      // Every byte lands in the buffer at the fill index; while hunting that is entry 0.
      function void absorb_byte(logic [7:0] rx);
         scfp_pkg::result_type outcome;
         int unsigned at;
         int unsigned n;
         int unsigned count;
         logic [63:0] gathered;
         at = next_index;
         store[at] = rx;
         if (at == 0 && rx != header_value) return;
         outcome = '0;
         outcome.command_byte = store[1];
         if (rx == tail_value) begin
            // The tail closes the frame wherever it stands, even as the command byte.
            case (store[1])
               scfp_pkg::CMD_INSTRUCTION: begin
                  instr_hold = store[1];
                  outcome.frame_kind = scfp_pkg::KIND_INSTRUCTION;
               end
               scfp_pkg::CMD_SPEED: begin
                  // Entries 2 and 3 are taken even from a short frame.
                  speed_a_hold = store[2];
                  speed_b_hold = store[3];
                  outcome.frame_kind = scfp_pkg::KIND_SPEED;
               end
               scfp_pkg::CMD_BUS: begin
                  gathered = '0;
                  count = 0;
                  for (n = 2; n < at && count < scfp_pkg::BUS_BYTES; n++) begin
                     gathered[8*count +: 8] = store[n];
                     count++;
                  end
                  outcome.bus_payload = gathered;
                  outcome.payload_length = 4'(count);
                  outcome.frame_kind = scfp_pkg::KIND_BUS;
               end
               default: outcome.frame_kind = scfp_pkg::KIND_UNKNOWN;
            endcase
         end else if (at + 1 < FRAME_DEPTH) begin
            next_index = at + 1;
            return;
         end else begin
            // A non-tail byte in the last entry drops the frame.
            outcome.frame_kind = scfp_pkg::KIND_OVERRUN;
         end
         outcome.instruction_value = instr_hold;
         outcome.speed_a = speed_a_hold;
         outcome.speed_b = speed_b_hold;
         awaited_results.push_back(outcome);
         next_index = 0;
      endfunction

      function void field_check(string label, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         end
      endfunction

      function void compare_result(logic [103:0] data);
         scfp_pkg::result_type got;
         scfp_pkg::result_type want;
         got = data[102:0];
         if (awaited_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result %0h, expected none", $time, data);
            return;
         end
         want = awaited_results.pop_front();
         checked++;
         kind_seen[want.frame_kind]++;
         field_check("frame_kind", 64'(want.frame_kind), 64'(got.frame_kind));
         field_check("command_byte", 64'(want.command_byte), 64'(got.command_byte));
         field_check("instruction_value", 64'(want.instruction_value),
                     64'(got.instruction_value));
         field_check("speed_a", 64'(want.speed_a), 64'(got.speed_a));
         field_check("speed_b", 64'(want.speed_b), 64'(got.speed_b));
         field_check("bus_payload", want.bus_payload, got.bus_payload);
         field_check("payload_length", 64'(want.payload_length), 64'(got.payload_length));
         field_check("pad bit", 64'(1'b0), 64'(data[103]));
      endfunction
   endclass

   frame_result_board board = new();

   function automatic logic [7:0] other_than(input logic [7:0] avoid);
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      if (v == avoid) v = v + 8'd1;
      return v;
   endfunction

   // Offers one byte and returns at the falling edge after its transfer, with the
   // valid still high. The caller either offers the next byte at that edge or
   // lowers the valid there, so the valid never sees two updates in one step.
   task automatic send_byte(input logic [7:0] rx);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= rx;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.absorb_byte(rx);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stops the input, waits for every awaited result, then lets the pipeline empty:
   // a byte that causes no result may still wait in the input register to be parsed.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_register(index, value);
      @(negedge clock);
   endtask

   // One random frame. Most are well formed with random content; the rest are line
   // noise, overruns and frames cut off by stray bytes. The weight returned counts
   // the bytes the parser actually works on, leaving out noise while hunting.
   task automatic send_random_frame(input logic [7:0] hdr, input logic [7:0] tl,
                                    output int unsigned weight);
      int unsigned pick;
      int unsigned len;
      logic [7:0]  cmd;
      pick = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      weight = 0;
      if (pick < 10) begin
         // Noise never matches the header, so a hunting parser keeps hunting.
         len = $urandom_range(1, 4);
         repeat (len) send_byte(other_than(hdr));
         return;
      end
      send_byte(hdr);
      weight = 1;
      // With header and tail equal, the header alone is a complete frame.
      if (hdr == tl) return;
      if (pick < 16) begin
         repeat (FRAME_DEPTH - 1) send_byte(other_than(tl));
         weight += FRAME_DEPTH - 1;
         return;
      end
      if (pick < 22) begin
         len = $urandom_range(1, 20);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
         weight += len;
         return;
      end
      case ($urandom_range(0, 3))
         0:       cmd = scfp_pkg::CMD_INSTRUCTION;
         1:       cmd = scfp_pkg::CMD_SPEED;
         2:       cmd = scfp_pkg::CMD_BUS;
         default: cmd = other_than(tl);
      endcase
      // Bus frames mostly stay short; now and then they run on to the last buffer entry,
      // where a payload byte instead of the tail turns the frame into an overrun.
      if (cmd == scfp_pkg::CMD_BUS)
         len = $urandom_range(0, ($urandom_range(0, 3) == 0) ? FRAME_DEPTH - 2 : 9);
      else
         len = $urandom_range(0, 3);
      send_byte(cmd);
      repeat (len) send_byte(other_than(tl));
      send_byte(tl);
      weight += len + 2;
   endtask

   task automatic run_phase(input logic [7:0] hdr, input logic [7:0] tl,
                            input int unsigned goal, input bit squeeze);
      int unsigned counted;
      int unsigned weight;
      settle();
      write_register(scfp_pkg::CSR_HEADER, hdr);
      write_register(scfp_pkg::CSR_TAIL, tl);
      settings_used++;
      if (squeeze) squeeze_now = 1'b1;
      counted = 0;
      while (counted < goal) begin
         send_random_frame(hdr, tl, weight);
         counted += weight;
      end
   endtask

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: ends the run if neither side completes a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still awaited",
                     $time, QUIET_LIMIT, board.awaited_results.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result side: before every transfer it stalls for a random number of cycles, and
   // once it stalls for a long stretch so that the output register stays full and
   // the block has to refuse input. Each transfer is checked as it happens.
   initial begin : result_sink
      int unsigned stall;
      bit          squeezed;
      squeezed = 1'b0;
      forever begin
         @(negedge clock);
         stall = calm ? 0 : $urandom_range(0, 15);
         if (squeeze_now && !squeezed) begin
            squeezed = 1'b1;
            stall += HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (reset || !(rsp_tvalid && rsp_tready)) @(posedge clock);
         board.compare_result(rsp_tdata);
      end
   end

   initial begin
      logic [7:0] opening [$];
      logic [7:0] hdr;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed opening at the reset header and tail. The first frame is a full
      // speed frame, which fills entries 0 to 4, so later reads of the command and
      // speed entries always find bytes written since reset.
      opening = '{scfp_pkg::HEADER_RESET, scfp_pkg::CMD_SPEED, 8'h05, 8'h06,
                  scfp_pkg::TAIL_RESET,
                  // Noise, including a tail while hunting, causes nothing.
                  8'hFF, scfp_pkg::TAIL_RESET,
                  scfp_pkg::HEADER_RESET, scfp_pkg::CMD_INSTRUCTION, scfp_pkg::TAIL_RESET,
                  scfp_pkg::HEADER_RESET, 8'hFF, scfp_pkg::TAIL_RESET,
                  // Bus frame with no payload byte.
                  scfp_pkg::HEADER_RESET, scfp_pkg::CMD_BUS, scfp_pkg::TAIL_RESET,
                  // Bus frame with exactly eight payload bytes, one of them the header.
                  scfp_pkg::HEADER_RESET, scfp_pkg::CMD_BUS, 8'h00, 8'hFF,
                  scfp_pkg::HEADER_RESET, 8'h01, 8'h80, 8'hAA, 8'h55, 8'hFE,
                  scfp_pkg::TAIL_RESET,
                  // Short speed frame: the speeds come from stale entries.
                  scfp_pkg::HEADER_RESET, scfp_pkg::CMD_SPEED, scfp_pkg::TAIL_RESET,
                  // The tail standing where the command belongs.
                  scfp_pkg::HEADER_RESET, scfp_pkg::TAIL_RESET};
      foreach (opening[i]) send_byte(opening[i]);

      // Random phases over several header and tail settings, the extremes among
      // them, plus one with header and tail equal. The first one carries the long
      // back-pressure stretch.
      run_phase(scfp_pkg::HEADER_RESET, scfp_pkg::TAIL_RESET, 350, 1'b1);
      run_phase(8'h00, 8'hFF, 300, 1'b0);
      run_phase(8'hFF, 8'h00, 300, 1'b0);
      run_phase(8'h55, 8'h55, 60, 1'b0);
      repeat (2) begin
         hdr = 8'($urandom_range(0, 255));
         run_phase(hdr, other_than(hdr), 300, 1'b0);
      end
      run_phase(scfp_pkg::HEADER_RESET, scfp_pkg::TAIL_RESET, 100, 1'b0);

      settle();
      repeat (4) @(negedge clock);
      $display("Sent %0d bytes in %0d phases (directed opening plus random header/tail runs);",
               bytes_sent, settings_used + 1);
      $display("%0d frame results checked: unknown %0d, instruction %0d, speed %0d, bus %0d, overrun %0d.",
               board.checked,
               board.kind_seen[scfp_pkg::KIND_UNKNOWN],
               board.kind_seen[scfp_pkg::KIND_INSTRUCTION],
               board.kind_seen[scfp_pkg::KIND_SPEED], board.kind_seen[scfp_pkg::KIND_BUS],
               board.kind_seen[scfp_pkg::KIND_OVERRUN]);
      if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
